### hdl/key_value_table_assert.svh
// ----------------------------------------------------------------------------
// key_value_table_assert.svh
// assertion macros of the key/value table checker
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_ASSERT_SVH
`define KEY_VALUE_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define KVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define KVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// types and codes of the key/value table
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PUT    = 2'd0;
  localparam kind_t KIND_GET    = 2'd1;
  localparam kind_t KIND_REMOVE = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic signed [VAL_W-1:0] NO_VALUE = '1;

  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

### hdl/kvt_if.sv
// ----------------------------------------------------------------------------
// kvt_if
// request and response channels of the key/value table
// ----------------------------------------------------------------------------
`default_nettype none

interface kvt_req_if;
  logic                                  valid;
  logic                                  ready;
  kvt_pkg::kind_t                        kind;
  logic signed [kvt_pkg::KEY_W-1:0]      key;
  logic signed [kvt_pkg::VAL_W-1:0]      value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface kvt_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  found;
  logic signed [kvt_pkg::VAL_W-1:0]      read_value;
  logic                                  status;

  modport source (output valid, output found, output read_value, output status,
                  input ready);
  modport sink   (input valid, input found, input read_value, input status,
                  output ready);
endinterface

`default_nettype wire

### hdl/kvt_ram.sv
// ----------------------------------------------------------------------------
// kvt_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_ram #(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/key_value_table.sv
// ----------------------------------------------------------------------------
// key_value_table
// bounded associative store of signed 32-bit keys and values
// ----------------------------------------------------------------------------
// usage:
//   req carries one operation per transaction: put, get or remove of a key.
//   rsp returns one transaction per request: found, read_value, status.
//   entries sit in one ram; each request scans all ENTRIES slots through
//   its single read port, one slot a cycle, with one key comparator.
//   requests are served one at a time, paced by the slot scan over the
//   ram read port.
//   req.ready is high only when no request is in work or waiting.
//   a put of a new key into a full table is dropped with status full.
//   reset: a clearing pass writes every slot invalid, with
//   req.ready low meanwhile.
//   stall: the response holds on rsp until rsp.ready; no request is taken
//   until then.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_table #(
  parameter int unsigned ENTRIES = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  kvt_req_if.sink    req,
  kvt_rsp_if.source  rsp
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned ENT_W = $bits(kvt_pkg::entry_t);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_DECIDE,
    ST_DONE
  } state_t;

  state_t state;

  logic [IDX_W-1:0] idx;
  logic             chk;
  logic [IDX_W-1:0] chk_idx;

  kvt_pkg::kind_t                        op_kind;
  logic signed [kvt_pkg::KEY_W-1:0]      op_key;
  logic signed [kvt_pkg::VAL_W-1:0]      op_value;

  logic                                  hit;
  logic [IDX_W-1:0]                      hit_idx;
  logic signed [kvt_pkg::VAL_W-1:0]      hit_value;
  logic                                  free_ok;
  logic [IDX_W-1:0]                      free_idx;

  logic                                  out_found;
  logic signed [kvt_pkg::VAL_W-1:0]      out_read_value;
  logic                                  out_status;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  kvt_pkg::entry_t  ram_wentry;
  logic [ENT_W-1:0] ram_rdata;
  kvt_pkg::entry_t  rd_entry;

  logic cur_hit;
  logic cur_free;

  kvt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ENT_W'(ram_wentry)),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign rd_entry = kvt_pkg::entry_t'(ram_rdata);

  // slot read last cycle is checked now
  assign cur_hit  = chk && rd_entry.valid && (rd_entry.key == op_key);
  assign cur_free = chk && !rd_entry.valid;

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wentry = '{valid: 1'b0, key: op_key, value: op_value};
    if (state == ST_CLEAR) begin
      ram_we     = 1'b1;
      ram_wentry = '0;
    end else if (state == ST_DECIDE) begin
      unique case (op_kind)
        kvt_pkg::KIND_PUT: begin
          ram_wentry.valid = 1'b1;
          if (hit) begin
            ram_we    = 1'b1;
            ram_waddr = hit_idx;
          end else if (free_ok) begin
            ram_we    = 1'b1;
            ram_waddr = free_idx;
          end
        end
        kvt_pkg::KIND_REMOVE: begin
          ram_we    = hit;
          ram_waddr = hit_idx;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      idx   <= '0;
      chk   <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (idx == LAST) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_IDLE: begin
          chk     <= 1'b0;
          hit     <= 1'b0;
          free_ok <= 1'b0;
          idx     <= '0;
          if (req.valid) begin
            op_kind  <= req.kind;
            op_key   <= req.key;
            op_value <= req.value;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN, ST_TAIL: begin
          if (cur_hit) begin
            hit       <= 1'b1;
            hit_idx   <= chk_idx;
            hit_value <= rd_entry.value;
          end
          if (cur_free && !free_ok) begin
            free_ok  <= 1'b1;
            free_idx <= chk_idx;
          end
          chk_idx <= idx;
          if (state == ST_TAIL) begin
            chk   <= 1'b0;
            state <= ST_DECIDE;
          end else begin
            chk <= 1'b1;
            if (idx == LAST) begin
              idx   <= '0;
              state <= ST_TAIL;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        ST_DECIDE: begin
          out_found      <= hit;
          out_read_value <= (op_kind == kvt_pkg::KIND_GET && hit) ? hit_value
                                                                  : kvt_pkg::NO_VALUE;
          out_status     <= (op_kind == kvt_pkg::KIND_PUT && !hit && !free_ok)
                            ? kvt_pkg::STATUS_FULL : kvt_pkg::STATUS_OK;
          state          <= ST_DONE;
        end
        ST_DONE: begin
          if (rsp.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = (state == ST_DONE);
  assign rsp.found      = out_found;
  assign rsp.read_value = out_read_value;
  assign rsp.status     = out_status;

endmodule

`default_nettype wire

### hdl/kvt_checker.sv
// ----------------------------------------------------------------------------
// kvt_checker
// port-level checks of the key/value table, bound to key_value_table
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_value_table_assert.svh"

module kvt_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             req_valid,
  input wire logic                             req_ready,
  input wire logic                             rsp_valid,
  input wire logic                             rsp_ready,
  input wire logic                             rsp_found,
  input wire logic signed [kvt_pkg::VAL_W-1:0] rsp_read_value,
  input wire logic                             rsp_status
);

  `KVT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")
  `KVT_ASSERT_NOW(a_busy_on_rsp, rsp_valid, !req_ready, "request taken with response pending")
  `KVT_ASSERT_NEXT(a_one_in_work, req_valid && req_ready, !req_ready, "second request taken")
  `KVT_ASSERT_NOW(a_miss_value, rsp_valid && !rsp_found, rsp_read_value == kvt_pkg::NO_VALUE, "miss with a value")
  `KVT_ASSERT_NOW(a_full_is_miss, rsp_valid && rsp_status == kvt_pkg::STATUS_FULL, !rsp_found, "full on a hit")

endmodule

bind key_value_table kvt_checker u_kvt_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_found      (rsp.found),
  .rsp_read_value (rsp.read_value),
  .rsp_status     (rsp.status)
);

`default_nettype wire

### verif/tb_key_value_table.sv
// ----------------------------------------------------------------------------
// tb_key_value_table
// self-checking testbench of the bounded key/value table
// ----------------------------------------------------------------------------
// A queue of operations drives put, get, remove and unused-kind transactions.
// It starts with a directed pass over the key and value extremes, then moves
// to random sequences that fill the table up to overflow, overwrite, drain
// it, and mix in noise. A shadow table predicts found, read_value and status
// for each accepted request. Each response is checked in order against that
// prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_key_value_table;
  timeunit 1ns;
  timeprecision 1ps;

  import kvt_pkg::*;

  localparam int unsigned ENTRIES     = 16;
  localparam int          RAND_OPS    = 400;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          POOL_SIZE   = 24;

  // the 2-bit kind field leaves one code without a meaning
  localparam kind_t KIND_NONE = 2'd3;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef struct {
    kind_t                   kind;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
    bit                      wait_idle;
  } kv_op_t;

  typedef struct {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    status;
  } kv_result_t;

  logic clk;
  logic rst;

  kvt_req_if req_ch ();
  kvt_rsp_if rsp_ch ();

  key_value_table #(.ENTRIES(ENTRIES)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  // shadow of the table
  bit                      shadow_valid [ENTRIES];
  logic signed [KEY_W-1:0] shadow_key   [ENTRIES];
  logic signed [VAL_W-1:0] shadow_value [ENTRIES];

  kv_op_t     op_q[$];
  kv_result_t expected_q[$];

  // keys live in the table as the stimulus generator sees it
  logic signed [KEY_W-1:0] live_keys[$];
  logic signed [KEY_W-1:0] key_pool[POOL_SIZE];

  int  error_cnt;
  int  accepted_cnt;
  int  cycle_cnt;
  bit  calm;
  int  gap_left;
  int  stall_left;
  kv_op_t next_op;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    error_cnt++;
  endtask

  function automatic kv_result_t apply_op(input kind_t kind,
                                          input logic signed [KEY_W-1:0] key,
                                          input logic signed [VAL_W-1:0] value);
    kv_result_t res;
    int hit;
    int free_idx;
    hit      = -1;
    free_idx = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_key[i] == key) hit = i;
      if (!shadow_valid[i]) free_idx = i;
    end
    res.found      = (hit >= 0);
    res.read_value = NO_VALUE;
    res.status     = STATUS_OK;
    case (kind)
      KIND_PUT: begin
        if (hit >= 0) begin
          shadow_value[hit] = value;
        end else if (free_idx >= 0) begin
          shadow_valid[free_idx] = 1'b1;
          shadow_key[free_idx]   = key;
          shadow_value[free_idx] = value;
        end else begin
          res.status = STATUS_FULL;
        end
      end
      KIND_GET: begin
        if (hit >= 0) res.read_value = shadow_value[hit];
      end
      KIND_REMOVE: begin
        if (hit >= 0) shadow_valid[hit] = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int live_index(input logic signed [KEY_W-1:0] key);
    foreach (live_keys[i]) if (live_keys[i] == key) return i;
    return -1;
  endfunction

  function automatic void add_op(input kind_t kind, input logic signed [KEY_W-1:0] key,
                                 input logic signed [VAL_W-1:0] value,
                                 input bit wait_idle = 1'b0);
    kv_op_t op;
    int idx;
    op.kind      = kind;
    op.key       = key;
    op.value     = value;
    op.wait_idle = wait_idle;
    op_q.push_back(op);
    idx = live_index(key);
    if (kind == KIND_PUT && idx < 0 && live_keys.size() < ENTRIES) live_keys.push_back(key);
    if (kind == KIND_REMOVE && idx >= 0) live_keys.delete(idx);
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    if (live_keys.size() != 0 && $urandom_range(0, 9) < 7)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return KIND_PUT;
    if (r < 70) return KIND_GET;
    if (r < 90) return KIND_REMOVE;
    return KIND_NONE;
  endfunction

  function automatic logic signed [KEY_W-1:0] fresh_key();
    logic signed [KEY_W-1:0] k;
    k = $urandom;
    while (live_index(k) >= 0) k = $urandom;
    return k;
  endfunction

  // puts new keys until every slot is taken, pushes past full, then overwrites and reads back live keys
  function automatic void fill_table(input bit wait_idle);
    logic signed [KEY_W-1:0] k;
    bit first;
    first = wait_idle;
    while (live_keys.size() < ENTRIES) begin
      add_op(KIND_PUT, fresh_key(), $urandom, first);
      first = 1'b0;
    end
    repeat ($urandom_range(1, 3)) add_op(KIND_PUT, fresh_key(), $urandom, first);
    repeat ($urandom_range(1, 3)) begin
      k = live_keys[$urandom_range(0, live_keys.size() - 1)];
      add_op(KIND_PUT, k, $urandom);
      add_op(KIND_GET, k, $urandom);
    end
  endfunction

  function automatic void drain_table();
    logic signed [KEY_W-1:0] k;
    while (live_keys.size() != 0) begin
      k = live_keys[$urandom_range(0, live_keys.size() - 1)];
      add_op(KIND_REMOVE, k, $urandom);
      if ($urandom_range(0, 3) == 0) add_op(KIND_GET, k, $urandom);
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_q.push_back(apply_op(req_ch.kind, req_ch.key, req_ch.value));
        accepted_cnt++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (op_q.size() != 0 && !(op_q[0].wait_idle && expected_q.size() != 0)) begin
          next_op = op_q.pop_front();
          req_ch.kind  <= next_op.kind;
          req_ch.key   <= next_op.key;
          req_ch.value <= next_op.value;
          req_ch.valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and checker
  always @(posedge clk) begin
    kv_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_q.size() == 0) begin
          report("response transaction with nothing outstanding");
        end else begin
          want = expected_q.pop_front();
          if (rsp_ch.found !== want.found)
            report($sformatf("found got %b want %b", rsp_ch.found, want.found));
          if (rsp_ch.read_value !== want.read_value)
            report($sformatf("read_value got %h want %h", rsp_ch.read_value,
                             want.read_value));
          if (rsp_ch.status !== want.status)
            report($sformatf("status got %b want %b", rsp_ch.status, want.status));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        rsp_ch.ready <= (stall_left == 0);
      end
    end
  end

  // stretches with no idling on either side
  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) calm <= ~calm;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int total;
    int directed_cnt;
    int r;
    clk          = 1'b0;
    rst          = 1'b1;
    calm         = 1'b0;
    error_cnt    = 0;
    accepted_cnt = 0;
    cycle_cnt    = 0;
    req_ch.valid = 1'b0;
    req_ch.kind  = KIND_PUT;
    req_ch.key   = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    foreach (shadow_valid[i]) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
    end

    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = '1;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // directed: empty table, extremes, overwrite, unused kind, removes
    add_op(KIND_GET, '0, '0);
    add_op(KIND_REMOVE, KEY_MAX, '1);
    add_op(KIND_NONE, 32'sd5, '0);
    add_op(KIND_PUT, KEY_MIN, KEY_MAX);
    add_op(KIND_PUT, KEY_MAX, KEY_MIN);
    add_op(KIND_PUT, '0, '1);
    add_op(KIND_GET, KEY_MIN, '0);
    add_op(KIND_GET, KEY_MAX, '1);
    add_op(KIND_GET, '0, '0);
    add_op(KIND_PUT, KEY_MAX, 32'sh1234_5678);
    add_op(KIND_GET, KEY_MAX, '0);
    add_op(KIND_NONE, KEY_MAX, '1);
    add_op(KIND_REMOVE, KEY_MIN, '0);
    add_op(KIND_GET, KEY_MIN, '0);
    add_op(KIND_REMOVE, KEY_MIN, '0);
    add_op(KIND_PUT, '1, '0);
    add_op(KIND_GET, '1, '1);
    add_op(KIND_NONE, KEY_MIN, '0);
    add_op(KIND_REMOVE, '0, '0);
    add_op(KIND_REMOVE, '1, '0);
    add_op(KIND_REMOVE, KEY_MAX, '0);
    directed_cnt = op_q.size();

    // first random sequence waits for the pipe to empty, then overflows
    fill_table(1'b1);
    while (op_q.size() < directed_cnt + RAND_OPS) begin
      r = $urandom_range(0, 9);
      if (r < 2) begin
        fill_table($urandom_range(0, 2) == 0);
      end else if (r == 2) begin
        drain_table();
      end else if (r == 3) begin
        repeat (8) add_op(kind_t'($urandom_range(0, 3)), $urandom, $urandom);
      end else begin
        repeat (10) add_op(pick_kind(), pick_key(), $urandom);
      end
    end
    total = op_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cnt < total || expected_q.size() != 0) @(negedge clk);
    repeat (ENTRIES + 8) @(negedge clk);

    if (error_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/kvt_pkg.sv
hdl/kvt_if.sv
hdl/kvt_ram.sv
hdl/key_value_table.sv
hdl/kvt_checker.sv
verif/tb_key_value_table.sv
